@@ hdl/analog_ladder_button_decoder_unit_assert.svh @@
// assertion macros used by the ladder keypad decoder sequencer
`ifndef ANALOG_LADDER_BUTTON_DECODER_UNIT_ASSERT_SVH
`define ANALOG_LADDER_BUTTON_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ADB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define ADB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/adb_pkg.sv @@
// types, constants and codes of the ladder keypad decoder
package adb_pkg;

	localparam int MAX_BUTTONS = 16;
	localparam int SAMPLE_BITS = 12;

	localparam int IDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
	localparam int CNT_W = $clog2(MAX_BUTTONS + 1);
	localparam int ID_W = 8;
	localparam int MS_W = 16;
	localparam int TIME_W = 32;
	localparam int MARGIN_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// request type codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_LOAD = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_MARGIN = 2'd1,
		REG_INTERVAL = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REL_RD,
		ST_REL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0] ident;
		logic [SAMPLE_BITS-1:0] level;
		logic [MS_W-1:0] hold_ms;
		logic [MS_W-1:0] rep_ms;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [MS_W-1:0] debounce_samples;
		logic [MARGIN_W-1:0] match_margin;
		logic [MS_W-1:0] sample_interval_ms;
	} cfg_t;

	typedef struct packed {
		logic wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t wr_data;
		logic rd_en;
		logic [IDX_W-1:0] rd_addr;
	} ram_req_t;

	typedef struct packed {
		logic valid;
		logic [ID_W-1:0] ident;
		logic held;
	} result_t;

endpackage

@@ hdl/adb_if.sv @@
// valid/ready channel interfaces of the ladder keypad decoder
interface adb_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [adb_pkg::SAMPLE_BITS-1:0] sample_level;
	logic [adb_pkg::TIME_W-1:0] now_ms;
	logic [adb_pkg::ID_W-1:0] button_id;
	logic [adb_pkg::SAMPLE_BITS-1:0] button_level;
	logic [adb_pkg::MS_W-1:0] hold_ms;
	logic [adb_pkg::MS_W-1:0] repeat_ms;

	modport source (
		output valid, req_type, sample_level, now_ms, button_id, button_level, hold_ms,
			repeat_ms,
		input ready
	);
	modport sink (
		input valid, req_type, sample_level, now_ms, button_id, button_level, hold_ms,
			repeat_ms,
		output ready
	);
endinterface

interface adb_evt_if;
	logic valid;
	logic ready;
	logic [adb_pkg::ID_W-1:0] event_id;
	logic event_held;

	modport source (output valid, event_id, event_held, input ready);
	modport sink (input valid, event_id, event_held, output ready);
endinterface

interface adb_cfg_if;
	logic valid;
	logic ready;
	logic [adb_pkg::CFG_IDX_W-1:0] reg_index;
	logic [adb_pkg::CFG_DATA_W-1:0] wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

@@ hdl/adb_entry_ram.sv @@
// single-port-write, single-port-read ram with registered read data
module adb_entry_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic wr_en,
	input logic [ADDR_W-1:0] wr_addr,
	input logic [WIDTH-1:0] wr_data,
	input logic rd_en,
	input logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hdl/adb_ctrl.sv @@
// sequencer: table append, entry scan, debounce, hold/repeat and click decisions
`include "analog_ladder_button_decoder_unit_assert.svh"

module adb_ctrl (
	input logic clk,
	input logic arst_n,
	adb_req_if.sink req,
	input adb_pkg::cfg_t cfg,
	input logic slot_free,
	input adb_pkg::entry_t rd_data,
	output adb_pkg::ram_req_t ram,
	output adb_pkg::result_t result
);

	localparam int LVL_W = adb_pkg::SAMPLE_BITS;
	localparam int SLVL_W = adb_pkg::SAMPLE_BITS + 2;

	adb_pkg::state_t state_q, state_d;

	logic [adb_pkg::CNT_W-1:0] entry_count_q;
	logic [adb_pkg::MAX_BUTTONS-1:0] held_q;
	logic [adb_pkg::TIME_W-1:0] last_q;
	logic cand_valid_q;
	logic [adb_pkg::IDX_W-1:0] cand_idx_q;
	logic pressed_valid_q;
	logic [adb_pkg::IDX_W-1:0] pressed_idx_q;
	logic [adb_pkg::MS_W-1:0] dc_q;
	logic [adb_pkg::TIME_W-1:0] mark_q;
	logic [adb_pkg::CNT_W-1:0] issue_q;
	logic cmp_valid_s1;
	logic [adb_pkg::IDX_W-1:0] cmp_idx_s1;
	logic [LVL_W-1:0] reading_q;
	logic [adb_pkg::TIME_W-1:0] now_q;
	logic [adb_pkg::ID_W-1:0] pend_id_q;
	logic pend_held_q;

	logic in_acc;
	logic is_load;
	logic table_full;
	logic sample_ok;
	logic [adb_pkg::TIME_W-1:0] gap;
	logic issue_go;
	logic hit;
	logic miss;
	logic signed [SLVL_W-1:0] win_lo;
	logic [LVL_W:0] win_hi;
	logic is_pressed;
	logic new_cand;
	logic [adb_pkg::MS_W-1:0] dc_base;
	logic [adb_pkg::MS_W-1:0] dc_next;
	logic [adb_pkg::TIME_W-1:0] elapsed;
	logic fire;
	logic click;

	assign in_acc = req.valid && req.ready;
	assign is_load = (req.req_type == adb_pkg::REQ_LOAD);
	assign table_full = (entry_count_q == adb_pkg::CNT_W'(adb_pkg::MAX_BUTTONS));
	assign gap = req.now_ms - last_q;
	assign sample_ok = gap > adb_pkg::TIME_W'(cfg.sample_interval_ms);

	// lower bound may go negative, so compare signed
	assign win_lo = $signed({2'b00, rd_data.level}) -
		$signed({{(SLVL_W-adb_pkg::MARGIN_W){1'b0}}, cfg.match_margin});
	assign win_hi = {1'b0, rd_data.level} + (LVL_W+1)'(cfg.match_margin);

	assign hit = (state_q == adb_pkg::ST_SCAN) && cmp_valid_s1 &&
		($signed({2'b00, reading_q}) >= win_lo) && ({1'b0, reading_q} <= win_hi);
	assign issue_go = (state_q == adb_pkg::ST_SCAN) && !hit && (issue_q < entry_count_q);
	assign miss = (state_q == adb_pkg::ST_SCAN) && !cmp_valid_s1 &&
		(issue_q >= entry_count_q);

	assign is_pressed = pressed_valid_q && (pressed_idx_q == cmp_idx_s1);
	assign new_cand = !(cand_valid_q && (cand_idx_q == cmp_idx_s1));
	assign dc_base = new_cand ? '0 : dc_q;
	assign dc_next = (dc_base != {adb_pkg::MS_W{1'b1}}) ? dc_base + 1'b1 : dc_base;

	assign elapsed = now_q - mark_q;
	assign fire = (!held_q[cmp_idx_s1] && (elapsed > adb_pkg::TIME_W'(rd_data.hold_ms))) ||
		(held_q[cmp_idx_s1] && (elapsed > adb_pkg::TIME_W'(rd_data.rep_ms)));
	assign click = pressed_valid_q && !held_q[pressed_idx_q];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			adb_pkg::ST_IDLE: begin
				if (in_acc && !is_load && sample_ok) begin
					state_d = adb_pkg::ST_SCAN;
				end
			end
			adb_pkg::ST_SCAN: begin
				if (hit) begin
					state_d = (is_pressed && fire) ? adb_pkg::ST_EMIT : adb_pkg::ST_IDLE;
				end else if (miss) begin
					state_d = click ? adb_pkg::ST_REL_RD : adb_pkg::ST_IDLE;
				end
			end
			adb_pkg::ST_REL_RD: state_d = adb_pkg::ST_REL;
			adb_pkg::ST_REL: state_d = adb_pkg::ST_EMIT;
			adb_pkg::ST_EMIT: begin
				if (slot_free) begin
					state_d = adb_pkg::ST_IDLE;
				end
			end
			default: state_d = adb_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready = 1'b0;
		ram = '0;
		ram.wr_addr = entry_count_q[adb_pkg::IDX_W-1:0];
		ram.wr_data.ident = req.button_id;
		ram.wr_data.level = req.button_level;
		ram.wr_data.hold_ms = req.hold_ms;
		ram.wr_data.rep_ms = req.repeat_ms;
		ram.rd_addr = issue_q[adb_pkg::IDX_W-1:0];
		result.valid = 1'b0;
		result.ident = pend_id_q;
		result.held = pend_held_q;
		case (state_q)
			adb_pkg::ST_IDLE: begin
				// ready is high throughout idle
				req.ready = 1'b1;
				ram.wr_en = req.valid && is_load && !table_full;
			end
			adb_pkg::ST_SCAN: ram.rd_en = issue_go;
			adb_pkg::ST_REL_RD: begin
				ram.rd_en = 1'b1;
				ram.rd_addr = pressed_idx_q;
			end
			adb_pkg::ST_REL: ram.rd_en = 1'b0;
			adb_pkg::ST_EMIT: result.valid = slot_free;
			default: ram.rd_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adb_pkg::ST_IDLE;
			entry_count_q <= '0;
			held_q <= '0;
			last_q <= '0;
			cand_valid_q <= 1'b0;
			cand_idx_q <= '0;
			pressed_valid_q <= 1'b0;
			pressed_idx_q <= '0;
			dc_q <= '0;
			mark_q <= '0;
			issue_q <= '0;
			cmp_valid_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram.wr_en) begin
				entry_count_q <= entry_count_q + 1'b1;
				held_q[entry_count_q[adb_pkg::IDX_W-1:0]] <= 1'b0;
			end
			if (state_q == adb_pkg::ST_IDLE && in_acc && !is_load && sample_ok) begin
				last_q <= req.now_ms;
				issue_q <= '0;
			end
			cmp_valid_s1 <= issue_go;
			if (issue_go) begin
				issue_q <= issue_q + 1'b1;
			end
			if (hit) begin
				if (!is_pressed) begin
					held_q[cmp_idx_s1] <= 1'b0;
					cand_valid_q <= 1'b1;
					cand_idx_q <= cmp_idx_s1;
					dc_q <= dc_next;
					if (dc_next >= cfg.debounce_samples) begin
						pressed_valid_q <= 1'b1;
						pressed_idx_q <= cmp_idx_s1;
						mark_q <= now_q;
					end
				end else if (fire) begin
					held_q[cmp_idx_s1] <= 1'b1;
					mark_q <= now_q;
				end
			end
			if (miss) begin
				pressed_valid_q <= 1'b0;
				cand_valid_q <= 1'b0;
			end
		end
	end

	// sample and pending-event payload
	always_ff @(posedge clk) begin
		if (state_q == adb_pkg::ST_IDLE && in_acc) begin
			reading_q <= req.sample_level;
			now_q <= req.now_ms;
		end
		if (issue_go) begin
			cmp_idx_s1 <= issue_q[adb_pkg::IDX_W-1:0];
		end
		if (hit) begin
			pend_id_q <= rd_data.ident;
			pend_held_q <= 1'b1;
		end else if (state_q == adb_pkg::ST_REL) begin
			pend_id_q <= rd_data.ident;
			pend_held_q <= 1'b0;
		end
	end

	`ADB_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1,
		entry_count_q <= adb_pkg::CNT_W'(adb_pkg::MAX_BUTTONS), "entry count beyond table")
	`ADB_ASSERT_NOW(a_pressed_cand, clk, arst_n, pressed_valid_q,
		cand_valid_q && ({1'b0, pressed_idx_q} < entry_count_q), "pressed without candidate")
	`ADB_ASSERT_NEXT(a_emit_hold, clk, arst_n, (state_q == adb_pkg::ST_EMIT) && !slot_free,
		(state_q == adb_pkg::ST_EMIT) && $stable(pend_id_q), "pending event lost")
	`ADB_ASSERT_NOW(a_ram_excl, clk, arst_n, ram.wr_en,
		!ram.rd_en && (state_q == adb_pkg::ST_IDLE), "table write during read")

endmodule

@@ hdl/analog_ladder_button_decoder_unit.sv @@
// top level of the resistor-ladder keypad decoder
// a load or an early sample is handled in idle; a held event reaches the output register
//   through the table scan and the emit step, a click through the scan, ST_REL_RD, ST_REL and emit
// throughput: a sample holds the block until its scan and any release and emit steps finish,
//   with the table scan reading one entry per cycle; a full output register stalls the emit step
// reset: arst_n clears control state, empties the table and loads defaults (5, 20, 20)
module analog_ladder_button_decoder_unit (
	input logic clk,
	input logic arst_n,
	adb_req_if.sink req,
	adb_evt_if.source evt,
	adb_cfg_if.sink cfg
);

	adb_pkg::cfg_t cfg_q;
	adb_pkg::ram_req_t ram;
	adb_pkg::entry_t rd_data;
	adb_pkg::result_t result;

	logic out_valid_q;
	logic [adb_pkg::ID_W-1:0] out_id_q;
	logic out_held_q;
	logic slot_free;
	logic [adb_pkg::ENTRY_W-1:0] rd_bits;

	// configuration writes are always taken; unknown indices are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_samples <= adb_pkg::MS_W'(5);
			cfg_q.match_margin <= adb_pkg::MARGIN_W'(20);
			cfg_q.sample_interval_ms <= adb_pkg::MS_W'(20);
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				adb_pkg::REG_DEBOUNCE: cfg_q.debounce_samples <= cfg.wr_data;
				adb_pkg::REG_MARGIN: cfg_q.match_margin <= cfg.wr_data[adb_pkg::MARGIN_W-1:0];
				adb_pkg::REG_INTERVAL: cfg_q.sample_interval_ms <= cfg.wr_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// button table: id, nominal level, hold and repeat times, one entry per word
	adb_entry_ram #(
		.WIDTH(adb_pkg::ENTRY_W),
		.DEPTH(adb_pkg::MAX_BUTTONS)
	) u_ram (
		.clk(clk),
		.wr_en(ram.wr_en),
		.wr_addr(ram.wr_addr),
		.wr_data(ram.wr_data),
		.rd_en(ram.rd_en),
		.rd_addr(ram.rd_addr),
		.rd_data(rd_bits)
	);

	assign rd_data = adb_pkg::entry_t'(rd_bits);

	// sequencer owns the press/hold state and walks the table
	adb_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cfg(cfg_q),
		.slot_free(slot_free),
		.rd_data(rd_data),
		.ram(ram),
		.result(result)
	);

	// output register: a finished event waits here while the next transaction is taken
	assign slot_free = !out_valid_q || evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.valid) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			out_id_q <= result.ident;
			out_held_q <= result.held;
		end
	end

	assign evt.valid = out_valid_q;
	assign evt.event_id = out_id_q;
	assign evt.event_held = out_held_q;

endmodule
